[sv/slbs_pkg.sv]
// ----------------------------------------------------------------------------
// slbs_pkg: status LED blink sequencer shared definitions
// Command codes, mode and phase codes, counter widths, the blink timing table
// and the beat structures passed between the sequencer stages.
// ----------------------------------------------------------------------------
package slbs_pkg;

   // timer ticks in one millisecond and width of the override down-counter
   localparam int unsigned TICKS_PER_MS  = 1;
   localparam int unsigned DURATION_BITS = 16;

   localparam int unsigned CMD_BITS      = 2;
   localparam int unsigned MODE_BITS     = 2;
   localparam int unsigned PHASE_BITS    = 2;
   localparam int unsigned DUR_MS_BITS   = 16;
   localparam int unsigned PHASE_MS_BITS = 10;

   // longest phase is 900 ms
   localparam int unsigned PHASE_MS_MAX    = 900;
   localparam int unsigned PHASE_TICK_BITS = $clog2(PHASE_MS_MAX * TICKS_PER_MS + 1);

   // duration product, wide enough to hold the saturation limit as well
   localparam int unsigned DUR_RAW_BITS  = DUR_MS_BITS + $clog2(TICKS_PER_MS + 1);
   localparam int unsigned DUR_PROD_BITS = (DUR_RAW_BITS > DURATION_BITS) ?
                                           DUR_RAW_BITS : DURATION_BITS;

   localparam logic [CMD_BITS-1:0] CMD_TICK      = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_SET_MODE  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_TEMP_MODE = 2'd2;

   localparam logic [MODE_BITS-1:0] MODE_STARTING   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CONNECTING = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_NORMAL     = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_FAULTED    = 2'd3;

   localparam logic [PHASE_BITS-1:0] PHASE_RED_ON    = 2'd0;
   localparam logic [PHASE_BITS-1:0] PHASE_RED_OFF   = 2'd1;
   localparam logic [PHASE_BITS-1:0] PHASE_GREEN_ON  = 2'd2;
   localparam logic [PHASE_BITS-1:0] PHASE_GREEN_OFF = 2'd3;

   typedef struct packed {
      logic [CMD_BITS-1:0]    cmd;
      logic [MODE_BITS-1:0]   mode;
      logic [DUR_MS_BITS-1:0] duration_ms;
   } req_item_type;

   typedef struct packed {
      logic                 red_on;
      logic                 green_on;
      logic [MODE_BITS-1:0] shown_mode;
      logic                 override_active;
   } rsp_item_type;

   typedef struct packed {
      logic                  found;
      logic [PHASE_BITS-1:0] phase;
   } phase_pick_type;

   // phase length in milliseconds per mode
   function automatic logic [PHASE_MS_BITS-1:0] phase_ms(
      input logic [MODE_BITS-1:0]  mode,
      input logic [PHASE_BITS-1:0] phase
   );
      logic [PHASE_MS_BITS-1:0] ms;
      ms = '0;
      case (mode)
         MODE_STARTING: begin
            case (phase)
               PHASE_RED_ON:  ms = 10'd100;
               PHASE_RED_OFF: ms = 10'd900;
               default:       ms = 10'd0;
            endcase
         end
         MODE_CONNECTING: begin
            case (phase)
               PHASE_RED_ON, PHASE_GREEN_ON: ms = 10'd125;
               default:                      ms = 10'd50;
            endcase
         end
         MODE_NORMAL: begin
            ms = (phase == PHASE_GREEN_ON) ? 10'd500 : 10'd0;
         end
         default: begin
            case (phase)
               PHASE_RED_ON:  ms = 10'd450;
               PHASE_RED_OFF: ms = 10'd50;
               default:       ms = 10'd0;
            endcase
         end
      endcase
      return ms;
   endfunction

   function automatic logic [PHASE_TICK_BITS-1:0] phase_ticks(
      input logic [MODE_BITS-1:0]  mode,
      input logic [PHASE_BITS-1:0] phase
   );
      logic [PHASE_TICK_BITS-1:0] ms_ext;
      ms_ext = PHASE_TICK_BITS'(phase_ms(mode, phase));
      return PHASE_TICK_BITS'(ms_ext * PHASE_TICK_BITS'(TICKS_PER_MS));
   endfunction

   // first phase at or after start with a nonzero length, no wrap
   function automatic phase_pick_type first_phase(
      input logic [MODE_BITS-1:0]  mode,
      input logic [PHASE_BITS-1:0] start
   );
      phase_pick_type pick;
      pick.found = 1'b0;
      pick.phase = start;
      for (int unsigned i = 0; i < 4; i++) begin
         if (!pick.found && (i >= int'(start)) &&
             (phase_ms(mode, PHASE_BITS'(i)) != '0)) begin
            pick.found = 1'b1;
            pick.phase = PHASE_BITS'(i);
         end
      end
      return pick;
   endfunction

endpackage

[sv/slbs_in_stage.sv]
// ----------------------------------------------------------------------------
// slbs_in_stage: input register
// Holds one request beat and hands it on when the result register has room.
// ----------------------------------------------------------------------------
module slbs_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  slbs_pkg::req_item_type req_item,
   input  logic                  out_free,
   output logic                  fire,
   output slbs_pkg::req_item_type item
);
   import slbs_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   assign fire      = valid_ff && out_free;
   assign req_ready = !valid_ff || fire;
   assign item      = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

[sv/slbs_seq_state.sv]
// ----------------------------------------------------------------------------
// slbs_seq_state: blink sequencer state
// Mode, override and phase registers with their next-value logic; gives the
// LED and mode result for the beat being committed.
// ----------------------------------------------------------------------------
module slbs_seq_state (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   commit,
   input  slbs_pkg::req_item_type item,
   output slbs_pkg::rsp_item_type result
);
   import slbs_pkg::*;

   logic [MODE_BITS-1:0]       permanent_mode_ff, permanent_mode_in;
   logic [MODE_BITS-1:0]       restore_mode_ff, restore_mode_in;
   logic [MODE_BITS-1:0]       override_mode_ff, override_mode_in;
   logic                       override_on_ff, override_on_in;
   logic [DURATION_BITS-1:0]   override_left_ff, override_left_in;
   logic [PHASE_BITS-1:0]      blink_phase_ff, blink_phase_in;
   logic [PHASE_TICK_BITS-1:0] phase_left_ff, phase_left_in;

   // tick path
   logic [DURATION_BITS-1:0]   left_dec;
   logic                       end_due;
   logic [MODE_BITS-1:0]       cur_mode;
   logic [MODE_BITS-1:0]       wrap_mode;
   phase_pick_type             pick_fwd;
   phase_pick_type             pick_wrap;
   logic                       need_wrap;
   logic [PHASE_BITS-1:0]      load_phase;
   logic [MODE_BITS-1:0]       load_mode;
   logic [PHASE_TICK_BITS-1:0] run_cnt;
   logic [PHASE_TICK_BITS-1:0] run_cnt_dec;
   logic [PHASE_BITS-1:0]      run_phase;

   // override start
   logic [DUR_PROD_BITS-1:0]   dur_prod;
   logic [DURATION_BITS-1:0]   dur_sat;

   logic [PHASE_BITS-1:0]      shown_phase;

   assign left_dec  = (override_on_ff && (override_left_ff != '0)) ?
                      override_left_ff - 1'b1 : override_left_ff;
   assign end_due   = override_on_ff && (left_dec == '0);
   assign cur_mode  = override_on_ff ? override_mode_ff : permanent_mode_ff;
   assign pick_fwd  = first_phase(cur_mode, blink_phase_ff);
   // override only ends when the search passes the red on phase
   assign need_wrap = ((blink_phase_ff == PHASE_RED_ON) && end_due) || !pick_fwd.found;
   assign wrap_mode = end_due ? restore_mode_ff : cur_mode;
   assign pick_wrap = first_phase(wrap_mode, PHASE_RED_ON);
   assign load_phase = need_wrap ? pick_wrap.phase : pick_fwd.phase;
   assign load_mode  = need_wrap ? wrap_mode : cur_mode;

   assign run_cnt     = (phase_left_ff == '0) ? phase_ticks(load_mode, load_phase)
                                              : phase_left_ff;
   assign run_phase   = (phase_left_ff == '0) ? load_phase : blink_phase_ff;
   assign run_cnt_dec = run_cnt - 1'b1;

   assign dur_prod = DUR_PROD_BITS'(item.duration_ms) * DUR_PROD_BITS'(TICKS_PER_MS);
   assign dur_sat  = (dur_prod > DUR_PROD_BITS'({DURATION_BITS{1'b1}})) ?
                     {DURATION_BITS{1'b1}} : DURATION_BITS'(dur_prod);

   always_comb begin
      permanent_mode_in = permanent_mode_ff;
      restore_mode_in   = restore_mode_ff;
      override_mode_in  = override_mode_ff;
      override_on_in    = override_on_ff;
      override_left_in  = override_left_ff;
      blink_phase_in    = blink_phase_ff;
      phase_left_in     = phase_left_ff;
      unique case (item.cmd)
         CMD_TICK: begin
            override_left_in = left_dec;
            if ((phase_left_ff == '0) && need_wrap && end_due) begin
               override_on_in    = 1'b0;
               permanent_mode_in = restore_mode_ff;
            end
            phase_left_in  = run_cnt_dec;
            blink_phase_in = (run_cnt_dec == '0) ? run_phase + 1'b1 : run_phase;
         end
         CMD_SET_MODE: begin
            if (override_on_ff) begin
               restore_mode_in = item.mode;
            end else begin
               permanent_mode_in = item.mode;
            end
         end
         CMD_TEMP_MODE: begin
            if (!override_on_ff && (item.duration_ms != '0)) begin
               restore_mode_in  = permanent_mode_ff;
               override_mode_in = item.mode;
               override_on_in   = 1'b1;
               override_left_in = dur_sat;
            end
         end
         default: begin
         end
      endcase
   end

   // after the last tick of a phase the previous phase is still on show
   assign shown_phase = (phase_left_in != '0) ? blink_phase_in : blink_phase_in - 1'b1;

   always_comb begin
      result.red_on          = (shown_phase == PHASE_RED_ON);
      result.green_on        = (shown_phase == PHASE_GREEN_ON);
      result.shown_mode      = override_on_in ? override_mode_in : permanent_mode_in;
      result.override_active = override_on_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         permanent_mode_ff <= MODE_STARTING;
         restore_mode_ff   <= MODE_STARTING;
         override_mode_ff  <= MODE_STARTING;
         override_on_ff    <= 1'b0;
         override_left_ff  <= '0;
         blink_phase_ff    <= PHASE_RED_ON;
         phase_left_ff     <= '0;
      end else if (commit) begin
         permanent_mode_ff <= permanent_mode_in;
         restore_mode_ff   <= restore_mode_in;
         override_mode_ff  <= override_mode_in;
         override_on_ff    <= override_on_in;
         override_left_ff  <= override_left_in;
         blink_phase_ff    <= blink_phase_in;
         phase_left_ff     <= phase_left_in;
      end
   end

endmodule

[sv/slbs_out_stage.sv]
// ----------------------------------------------------------------------------
// slbs_out_stage: result register
// Holds one result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module slbs_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  slbs_pkg::rsp_item_type result,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output slbs_pkg::rsp_item_type rsp_item
);
   import slbs_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign out_free  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

endmodule

[sv/status_led_blink_sequencer_core.sv]
// ----------------------------------------------------------------------------
// status_led_blink_sequencer_core: status LED blink sequencer
// Steps red and green LEDs through a per-mode blink cycle with a timed
// temporary mode override.
// ----------------------------------------------------------------------------
// One beat in, one result beat out. A request is taken into the input
// register; the sequencer state is then updated and the result registered
// once the result register has room, where it waits until it is taken.
// A new request is accepted
// every cycle while results are taken; the only stall comes from rsp_ready low
// with both registers full. Ticks
// (cmd 0) advance the blink phase counter, cmd 1 sets the permanent mode and
// cmd 2 starts a temporary override for duration_ms milliseconds; the LED and
// mode outputs reflect the state after each beat.
module status_led_blink_sequencer_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [slbs_pkg::CMD_BITS-1:0]    req_cmd,
   input  logic [slbs_pkg::MODE_BITS-1:0]   req_mode,
   input  logic [slbs_pkg::DUR_MS_BITS-1:0] req_duration_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_red_on,
   output logic                             rsp_green_on,
   output logic [slbs_pkg::MODE_BITS-1:0]   rsp_shown_mode,
   output logic                             rsp_override_active
);
   import slbs_pkg::*;

   req_item_type req_item;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type rsp_item;
   logic         out_free;
   logic         fire;

   assign req_item.cmd         = req_cmd;
   assign req_item.mode        = req_mode;
   assign req_item.duration_ms = req_duration_ms;

   slbs_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .out_free  (out_free),
      .fire      (fire),
      .item      (item)
   );

   slbs_seq_state u_seq_state (
      .clock  (clock),
      .reset  (reset),
      .commit (fire),
      .item   (item),
      .result (result)
   );

   slbs_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_red_on          = rsp_item.red_on;
   assign rsp_green_on        = rsp_item.green_on;
   assign rsp_shown_mode      = rsp_item.shown_mode;
   assign rsp_override_active = rsp_item.override_active;

   // a beat handed to the result register must show up there next cycle
   a_fire_gives_rsp : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("result beat lost after hand-over");

   // input is held off only while a result beat waits to be taken
   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled with result side free");

   // the two LEDs are never lit together
   a_leds_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_red_on && rsp_green_on))
      else $error("red and green lit together");

   // nothing is offered straight after reset
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered after reset");

endmodule

[tb/status_led_blink_sequencer_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// status_led_blink_sequencer_core_tb: self-checking bench for the LED sequencer
// A short scripted run over every command, mode and duration extreme, then
// random beats weighted towards ticks. Each accepted request is fed into a
// behavioural copy; each result is checked against it or a fixed script row.
// ----------------------------------------------------------------------------
module status_led_blink_sequencer_core_tb;
   import slbs_pkg::*;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED   = 2'd3;
   localparam int unsigned         RANDOM_ITEMS = 1080;
   localparam int unsigned         CYCLE_LIMIT  = 150000;
   localparam int unsigned         SCRIPT_ROWS  = 16;

   // phase length in ms, indexed by {mode, phase}
   localparam logic [15:0][9:0] BLINK_MS = {
      10'd0,  10'd0,   10'd50, 10'd450,
      10'd0,  10'd500, 10'd0,  10'd0,
      10'd50, 10'd125, 10'd50, 10'd125,
      10'd0,  10'd0,   10'd900, 10'd100
   };

   typedef struct packed {
      logic [CMD_BITS-1:0]    cmd;
      logic [MODE_BITS-1:0]   mode;
      logic [DUR_MS_BITS-1:0] duration_ms;
      logic                   fixed;
      rsp_item_type           want;
   } script_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [CMD_BITS-1:0]    req_cmd = CMD_TICK;
   logic [MODE_BITS-1:0]   req_mode = MODE_STARTING;
   logic [DUR_MS_BITS-1:0] req_duration_ms = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_red_on;
   logic                   rsp_green_on;
   logic [MODE_BITS-1:0]   rsp_shown_mode;
   logic                   rsp_override_active;

   // sequencer state as seen by the predictor
   logic [MODE_BITS-1:0]       held_mode   = MODE_STARTING;
   logic [MODE_BITS-1:0]       resume_mode = MODE_STARTING;
   logic [MODE_BITS-1:0]       temp_mode   = MODE_STARTING;
   logic                       temp_on     = 1'b0;
   logic [DURATION_BITS-1:0]   temp_left   = '0;
   logic [PHASE_BITS-1:0]      cycle_phase = PHASE_RED_ON;
   logic [PHASE_TICK_BITS-1:0] phase_left  = '0;

   rsp_item_type   display_queue[$];
   rsp_item_type   oldest;
   script_row_type script [SCRIPT_ROWS];
   int unsigned    mismatch_count = 0;
   int unsigned    cycle_count = 0;
   bit             steady = 1'b0;

   status_led_blink_sequencer_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_mode           (req_mode),
      .req_duration_ms    (req_duration_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_red_on         (rsp_red_on),
      .rsp_green_on       (rsp_green_on),
      .rsp_shown_mode     (rsp_shown_mode),
      .rsp_override_active(rsp_override_active)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // advances the sequencer copy by one request and returns the LED display
   function automatic rsp_item_type predict_display(
      input logic [CMD_BITS-1:0]    cmd,
      input logic [MODE_BITS-1:0]   mode,
      input logic [DUR_MS_BITS-1:0] dur
   );
      logic [PHASE_BITS-1:0]      k;
      logic [PHASE_BITS-1:0]      lit;
      logic [MODE_BITS-1:0]       active;
      logic [PHASE_TICK_BITS-1:0] len;
      longint unsigned            span;
      bit                         found;
      rsp_item_type               r;
      case (cmd)
         CMD_TICK: begin
            if (temp_on && temp_left != '0)
               temp_left = temp_left - 1'b1;
            if (phase_left == '0) begin
               k = cycle_phase;
               len = '0;
               found = 1'b0;
               for (int n = 0; n < 8; n++) begin
                  if (!found) begin
                     // override expires only on entry to red on
                     if (k == PHASE_RED_ON && temp_on && temp_left == '0) begin
                        temp_on = 1'b0;
                        held_mode = resume_mode;
                     end
                     active = temp_on ? temp_mode : held_mode;
                     len = PHASE_TICK_BITS'(BLINK_MS[{active, k}] * TICKS_PER_MS);
                     if (len != '0)
                        found = 1'b1;
                     else
                        k = k + 1'b1;
                  end
               end
               cycle_phase = k;
               phase_left = len;
            end
            if (phase_left != '0) begin
               phase_left = phase_left - 1'b1;
               if (phase_left == '0)
                  cycle_phase = cycle_phase + 1'b1;
            end
         end
         CMD_SET_MODE: begin
            if (temp_on)
               resume_mode = mode;
            else
               held_mode = mode;
         end
         CMD_TEMP_MODE: begin
            if (!temp_on && dur != '0) begin
               span = longint'(dur) * TICKS_PER_MS;
               resume_mode = held_mode;
               temp_mode = mode;
               temp_on = 1'b1;
               temp_left = (span > {DURATION_BITS{1'b1}}) ? '1 : DURATION_BITS'(span);
            end
         end
         default: begin
         end
      endcase
      lit = (phase_left != '0) ? cycle_phase : cycle_phase - 1'b1;
      r.red_on = (lit == PHASE_RED_ON);
      r.green_on = (lit == PHASE_GREEN_ON);
      r.shown_mode = temp_on ? temp_mode : held_mode;
      r.override_active = temp_on;
      return r;
   endfunction

   function automatic script_row_type stim_row(
      input logic [CMD_BITS-1:0]    cmd,
      input logic [MODE_BITS-1:0]   mode,
      input logic [DUR_MS_BITS-1:0] dur,
      input logic                   fixed,
      input logic                   red,
      input logic                   green,
      input logic [MODE_BITS-1:0]   shown,
      input logic                   temp
   );
      script_row_type s;
      s.cmd = cmd;
      s.mode = mode;
      s.duration_ms = dur;
      s.fixed = fixed;
      s.want.red_on = red;
      s.want.green_on = green;
      s.want.shown_mode = shown;
      s.want.override_active = temp;
      return s;
   endfunction

   task automatic send_beat(
      input logic [CMD_BITS-1:0]    cmd,
      input logic [MODE_BITS-1:0]   mode,
      input logic [DUR_MS_BITS-1:0] dur,
      input logic                   fixed,
      input rsp_item_type           want
   );
      rsp_item_type predicted;
      while (!steady && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_mode <= mode;
      req_duration_ms <= dur;
      do
         @(posedge clock);
      while (!req_ready);
      predicted = predict_display(cmd, mode, dur);
      display_queue.push_back(fixed ? want : predicted);
   endtask

   task automatic wait_for_drain;
      req_valid <= 1'b0;
      while (display_queue.size() != 0)
         @(posedge clock);
   endtask

   // result side: check each beat taken, then pick ready for the next edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (display_queue.size() == 0) begin
            report_mismatch("result beat with nothing pending", 1, 0);
         end else begin
            oldest = display_queue.pop_front();
            if (rsp_red_on !== oldest.red_on)
               report_mismatch("red_on", int'(rsp_red_on), int'(oldest.red_on));
            if (rsp_green_on !== oldest.green_on)
               report_mismatch("green_on", int'(rsp_green_on), int'(oldest.green_on));
            if (rsp_shown_mode !== oldest.shown_mode)
               report_mismatch("shown_mode", int'(rsp_shown_mode), int'(oldest.shown_mode));
            if (rsp_override_active !== oldest.override_active)
               report_mismatch("override_active", int'(rsp_override_active),
                               int'(oldest.override_active));
         end
      end
      rsp_ready <= steady || ($urandom_range(99) >= 6);
   end

   initial begin
      logic [CMD_BITS-1:0]    cmd;
      logic [MODE_BITS-1:0]   mode;
      logic [DUR_MS_BITS-1:0] dur;
      int unsigned            pick;
      int unsigned            random_count;
      bit                     counted;

      // nothing lit before the first tick, unused command still answered
      script[0]  = stim_row(CMD_UNUSED, MODE_FAULTED, 16'hFFFF, 1'b1,
                            1'b0, 1'b0, MODE_STARTING, 1'b0);
      script[1]  = stim_row(CMD_TICK, MODE_STARTING, 16'h0000, 1'b1,
                            1'b1, 1'b0, MODE_STARTING, 1'b0);
      // zero duration override is dropped
      script[2]  = stim_row(CMD_TEMP_MODE, MODE_FAULTED, 16'h0000, 1'b1,
                            1'b1, 1'b0, MODE_STARTING, 1'b0);
      script[3]  = stim_row(CMD_SET_MODE, MODE_NORMAL, 16'h0000, 1'b1,
                            1'b1, 1'b0, MODE_NORMAL, 1'b0);
      script[4]  = stim_row(CMD_TEMP_MODE, MODE_CONNECTING, 16'h0001, 1'b1,
                            1'b1, 1'b0, MODE_CONNECTING, 1'b1);
      // second override while one is running is dropped
      script[5]  = stim_row(CMD_TEMP_MODE, MODE_FAULTED, 16'hFFFF, 1'b1,
                            1'b1, 1'b0, MODE_CONNECTING, 1'b1);
      script[6]  = stim_row(CMD_SET_MODE, MODE_FAULTED, 16'h0000, 1'b0,
                            1'b0, 1'b0, MODE_STARTING, 1'b0);
      script[7]  = stim_row(CMD_TICK, MODE_STARTING, 16'hFFFF, 1'b0,
                            1'b0, 1'b0, MODE_STARTING, 1'b0);
      script[8]  = stim_row(CMD_UNUSED, MODE_STARTING, 16'h0000, 1'b0,
                            1'b0, 1'b0, MODE_STARTING, 1'b0);
      script[9]  = stim_row(CMD_TICK, MODE_CONNECTING, 16'h5555, 1'b0,
                            1'b0, 1'b0, MODE_STARTING, 1'b0);
      script[10] = stim_row(CMD_SET_MODE, MODE_STARTING, 16'hAAAA, 1'b0,
                            1'b0, 1'b0, MODE_STARTING, 1'b0);
      script[11] = stim_row(CMD_SET_MODE, MODE_CONNECTING, 16'h0000, 1'b0,
                            1'b0, 1'b0, MODE_STARTING, 1'b0);
      script[12] = stim_row(CMD_TEMP_MODE, MODE_NORMAL, 16'h8000, 1'b0,
                            1'b0, 1'b0, MODE_STARTING, 1'b0);
      script[13] = stim_row(CMD_TEMP_MODE, MODE_NORMAL, 16'h5555, 1'b0,
                            1'b0, 1'b0, MODE_STARTING, 1'b0);
      script[14] = stim_row(CMD_TEMP_MODE, MODE_STARTING, 16'hAAAA, 1'b0,
                            1'b0, 1'b0, MODE_STARTING, 1'b0);
      script[15] = stim_row(CMD_TICK, MODE_FAULTED, 16'h0000, 1'b0,
                            1'b0, 1'b0, MODE_STARTING, 1'b0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < SCRIPT_ROWS; i++)
         send_beat(script[i].cmd, script[i].mode, script[i].duration_ms,
                   script[i].fixed, script[i].want);

      // hold off until the pipeline is empty
      wait_for_drain();

      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         steady = (random_count >= 250 && random_count < 450);
         pick = $urandom_range(99);
         if (pick < 84)
            cmd = CMD_TICK;
         else if (pick < 91)
            cmd = CMD_SET_MODE;
         else if (pick < 98)
            cmd = CMD_TEMP_MODE;
         else
            cmd = CMD_UNUSED;
         // connecting has the shortest phases, so favour it
         mode = ($urandom_range(99) < 40) ? MODE_CONNECTING : MODE_BITS'($urandom_range(3));
         dur = DUR_MS_BITS'($urandom_range(65535));
         if (cmd == CMD_TEMP_MODE && !temp_on) begin
            pick = $urandom_range(99);
            if (pick < 85)
               dur = DUR_MS_BITS'($urandom_range(60, 1));
            else if (pick < 97)
               dur = DUR_MS_BITS'($urandom_range(1200, 61));
            else
               dur = '0;
         end
         counted = !(cmd == CMD_UNUSED ||
                     (cmd == CMD_TEMP_MODE && (temp_on || dur == '0)));
         send_beat(cmd, mode, dur, 1'b0, '0);
         if (counted)
            random_count++;
      end
      steady = 1'b0;

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && display_queue.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
